// ----- sv/sorted_coordinate_sparse_store_macros.svh -----
// assertion macros for the sorted coordinate sparse store
// included by modules that check their own logic; needs clk and rst_n in scope
`ifndef SORTED_COORDINATE_SPARSE_STORE_MACROS_SVH
`define SORTED_COORDINATE_SPARSE_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SCSS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define SCSS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCSS_ASSERT_HOLDS(label, cond, msg)

`define SCSS_ASSERT_IMPLIES(label, ante, cons, msg)

`define SCSS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/scss_pkg.sv -----
// shared types and constants of the sorted coordinate sparse store
// no dependencies
package scss_pkg;

    localparam int ROW_W      = 10;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int LIMIT_W    = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_INDEX_WIDTH = 10;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [ROW_W-1:0]   RESET_ROW_COUNT    = 10'd1023;
    localparam logic [ROW_W-1:0]   RESET_COLUMN_COUNT = 10'd1023;
    localparam logic [LIMIT_W-1:0] RESET_ENTRY_LIMIT  = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LIMIT  = 2'd2;

    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                    action;
        logic [ROW_W-1:0]        row_index;
        logic [ROW_W-1:0]        column_index;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      stored_count;
    } rsp_t;

endpackage

// ----- sv/scss_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module scss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sorted_coordinate_sparse_store.sv -----
// sorted coordinate-list sparse matrix store, top level
// depends on scss_pkg, scss_ram and sorted_coordinate_sparse_store_macros.svh
//
//   channel  signals                          direction
//   req      req_valid, req_stall, req        item in
//   rsp      rsp_valid, rsp_stall, rsp        item out
//   cfg      cfg_write, cfg_index, cfg_data   register write
//
// one item at a time; a read or in-place overwrite scans the sorted entries in order,
// all through the one read port of the entry ram
// an insert or removal then moves the later entries by one place, one entry at a time
// an out-of-range item skips the scan and goes straight to the response
// reset clears the entry count and reloads the config registers; the entry ram needs no clearing pass
// a finished item waits in the rsp register while rsp_stall is high
module sorted_coordinate_sparse_store
    import scss_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "sorted_coordinate_sparse_store_macros.svh"

    localparam int IW = INDEX_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 2 * IW + VW;
    localparam int KW = ((IW > ROW_W) ? IW : ROW_W) + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_ACT    = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ROW_W-1:0]    row_count_reg, row_count_next;
    logic [ROW_W-1:0]    col_count_reg, col_count_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                act_reg, act_next;
    logic [IW-1:0]       row_reg, row_next;
    logic [IW-1:0]       col_reg, col_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                found_reg, found_next;
    logic [VW-1:0]       hold_reg, hold_next;
    logic [CW-1:0]       src_reg, src_next;
    logic [CW-1:0]       left_reg, left_next;
    logic [AW-1:0]       last_reg, last_next;
    logic                ins_reg, ins_next;
    logic [VAL_W-1:0]    res_val_reg, res_val_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    rsp_t                rsp_reg, rsp_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    logic [IW-1:0]       req_row;
    logic [IW-1:0]       req_col;
    logic                range_bad;
    logic [IW-1:0]       rd_row;
    logic [IW-1:0]       rd_col;
    logic                entry_ge;
    logic                entry_eq;
    logic                store_full;
    logic signed [VW-1:0] hold_s;

    scss_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_row   = IW'(req.row_index);
    assign req_col   = IW'(req.column_index);
    assign range_bad = (req_row == '0) || (req_col == '0)
                    || (KW'(req_row) > KW'(row_count_reg))
                    || (KW'(req_col) > KW'(col_count_reg));

    assign rd_row   = ram_rdata[EW-1 -: IW];
    assign rd_col   = ram_rdata[VW +: IW];
    assign entry_eq = (rd_row == row_reg) && (rd_col == col_reg);
    assign entry_ge = (rd_row > row_reg) || ((rd_row == row_reg) && (rd_col >= col_reg));

    assign store_full = (LW'(count_reg) >= LW'(limit_reg)) || (count_reg >= CW'(CAPACITY));
    assign hold_s     = hold_reg;
    assign ram_raddr  = (state_reg == ST_SHIFT) ? src_reg[AW-1:0] : scan_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        act_next        = act_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        scan_next       = scan_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        hold_next       = hold_reg;
        src_next        = src_reg;
        left_next       = left_reg;
        last_next       = last_reg;
        ins_next        = ins_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[AW-1:0];
        ram_wdata       = {row_reg, col_reg, val_reg};

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_next = cfg_data[ROW_W-1:0];
                CFG_COLUMN_COUNT: col_count_next = cfg_data[ROW_W-1:0];
                CFG_ENTRY_LIMIT:  limit_next     = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next        = req.action;
                    row_next        = req_row;
                    col_next        = req_col;
                    val_next        = VW'($unsigned(req.write_value));
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    res_val_next    = '0;
                    res_status_next = STATUS_OK;
                    if (range_bad)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // compare the entry read last cycle, else issue the next read
                if (pend_reg && entry_ge)
                begin
                    pos_next   = scan_reg - CW'(1);
                    found_next = entry_eq;
                    hold_next  = ram_rdata[VW-1:0];
                    pend_next  = 1'b0;
                    state_next = ST_ACT;
                end
                else if (scan_reg == count_reg)
                begin
                    pos_next   = count_reg;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_ACT;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            ST_ACT:
            begin
                pend_next = 1'b0;
                priority if (act_reg == ACTION_READ)
                begin
                    res_val_next = found_reg ? VAL_W'(hold_s) : '0;
                    state_next   = ST_FINISH;
                end
                else if (found_reg && (val_reg != '0))
                begin
                    ram_we     = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (found_reg)
                begin
                    // removal: pull later entries down by one
                    ins_next   = 1'b0;
                    src_next   = pos_reg + CW'(1);
                    left_next  = count_reg - pos_reg - CW'(1);
                    state_next = ST_SHIFT;
                end
                else if (val_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (store_full)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    // insert: push entries from the end up by one
                    ins_next   = 1'b1;
                    src_next   = count_reg - CW'(1);
                    left_next  = count_reg - pos_reg;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ins_reg ? (last_reg + AW'(1)) : (last_reg - AW'(1));
                    ram_wdata = ram_rdata;
                end
                if (left_reg != '0)
                begin
                    src_next  = ins_reg ? (src_reg - CW'(1)) : (src_reg + CW'(1));
                    left_next = left_reg - CW'(1);
                    last_next = src_reg[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (ins_reg)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.read_value   = res_val_reg;
                    rsp_next.status       = res_status_reg;
                    rsp_next.stored_count = COUNT_W'(count_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= RESET_ROW_COUNT;
            col_count_reg <= RESET_COLUMN_COUNT;
            limit_reg     <= RESET_ENTRY_LIMIT;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        scan_reg       <= scan_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        hold_reg       <= hold_next;
        src_reg        <= src_next;
        left_reg       <= left_next;
        last_reg       <= last_next;
        ins_reg        <= ins_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    `SCSS_ASSERT_HOLDS(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `SCSS_ASSERT_IMPLIES(a_scan_no_write, state_reg == ST_SCAN, !ram_we, "ram write during scan")
    `SCSS_ASSERT_NEXT(a_count_only_in_shift, state_reg != ST_SHIFT, count_reg == $past(count_reg), "entry count changed outside shift")
    `SCSS_ASSERT_NEXT(a_rsp_from_finish, state_reg != ST_FINISH && !rsp_valid_reg, !rsp_valid_reg, "response raised outside finish")

endmodule

// ----- tb/sparse_store_checker.sv -----
// checker for the sorted coordinate sparse store: watches the request, response and
// register write ports, predicts each response and compares it field by field
// depends on scss_pkg
module sparse_store_checker
    import scss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  req_t                   req,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  rsp_t                   rsp,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2*ROW_W-1:0]      occupied_keys [DEF_CAPACITY];
    logic signed [VAL_W-1:0] occupied_values [DEF_CAPACITY];
    int                      occupied;

    logic [ROW_W-1:0]   row_bound;
    logic [ROW_W-1:0]   column_bound;
    logic [LIMIT_W-1:0] entry_cap;

    rsp_t awaited_replies [$];
    rsp_t wanted;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic rsp_t apply_access(input req_t item);
        rsp_t               result;
        logic [2*ROW_W-1:0] key;
        int                 slot;
        int                 cap_now;
        bit                 located;
        bit                 hit;
        result = '0;
        result.status = STATUS_OK;
        key = {item.row_index, item.column_index};
        cap_now = (entry_cap > DEF_CAPACITY) ? DEF_CAPACITY : int'(entry_cap);
        if (item.row_index == '0 || item.column_index == '0 ||
            item.row_index > row_bound || item.column_index > column_bound)
        begin
            result.status = STATUS_RANGE;
        end
        else
        begin
            slot = occupied;
            located = 1'b0;
            hit = 1'b0;
            for (int k = 0; k < occupied && !located; k++)
            begin
                if (occupied_keys[k] >= key)
                begin
                    slot = k;
                    located = 1'b1;
                    hit = (occupied_keys[k] == key);
                end
            end
            if (item.action == ACTION_READ)
            begin
                if (hit)
                    result.read_value = occupied_values[slot];
            end
            else if (hit)
            begin
                if (item.write_value == '0)
                begin
                    for (int k = slot; k < occupied - 1; k++)
                    begin
                        occupied_keys[k] = occupied_keys[k+1];
                        occupied_values[k] = occupied_values[k+1];
                    end
                    occupied--;
                end
                else
                begin
                    occupied_values[slot] = item.write_value;
                end
            end
            else if (item.write_value != '0)
            begin
                if (occupied >= cap_now)
                begin
                    result.status = STATUS_FULL;
                end
                else
                begin
                    for (int k = occupied; k > slot; k--)
                    begin
                        occupied_keys[k] = occupied_keys[k-1];
                        occupied_values[k] = occupied_values[k-1];
                    end
                    occupied_keys[slot] = key;
                    occupied_values[slot] = item.write_value;
                    occupied++;
                end
            end
        end
        result.stored_count = COUNT_W'(occupied);
        return result;
    endfunction

    initial
    begin
        mismatch_count = 0;
        awaited_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied = 0;
            row_bound = RESET_ROW_COUNT;
            column_bound = RESET_COLUMN_COUNT;
            entry_cap = RESET_ENTRY_LIMIT;
            awaited_replies.delete();
            awaited_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT:    row_bound = cfg_data[ROW_W-1:0];
                    CFG_COLUMN_COUNT: column_bound = cfg_data[ROW_W-1:0];
                    CFG_ENTRY_LIMIT:  entry_cap = cfg_data[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            if (req_valid && !req_stall)
                awaited_replies.push_back(apply_access(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch($sformatf("item with none expected: value %0d status %0d count %0d",
                        rsp.read_value, rsp.status, rsp.stored_count));
                end
                else
                begin
                    wanted = awaited_replies.pop_front();
                    if (rsp.read_value !== wanted.read_value)
                        report_mismatch($sformatf("read_value %0d, expected %0d",
                            rsp.read_value, wanted.read_value));
                    if (rsp.status !== wanted.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            rsp.status, wanted.status));
                    if (rsp.stored_count !== wanted.stored_count)
                        report_mismatch($sformatf("stored_count %0d, expected %0d",
                            rsp.stored_count, wanted.stored_count));
                end
            end
            awaited_count = awaited_replies.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the sorted coordinate sparse store testbench: clock, reset, stimulus and verdict
// depends on scss_pkg, sorted_coordinate_sparse_store and sparse_store_checker
module tb_top;
    import scss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 160;

    localparam int SETTLE_CYCLES = 20;
    localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VALUE_MIN = 32'sh80000000;

    int phase_rows   [PHASES] = '{1023, 8, 1, 0, 12, 6, 1023, 1023, 1023, 40, 1023, 3};
    int phase_cols   [PHASES] = '{1023, 8, 1, 5, 12, 1023, 3, 1023, 1023, 700, 1023, 1023};
    int phase_limit  [PHASES] = '{64, 64, 1, 10, 20, 0, 127, 'h3c5, 5, 64, 64, 32};
    int phase_span   [PHASES] = '{8, 8, 2, 4, 12, 6, 16, 30, 4, 40, 1023, 3};
    int phase_remove [PHASES] = '{15, 10, 30, 20, 20, 40, 10, 25, 20, 5, 30, 50};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatch_count;
    int awaited_count;
    int sender_idle = 10;
    int receiver_stall = 52;
    int rows_now = 1023;
    int cols_now = 1023;

    sorted_coordinate_sparse_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sparse_store_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < receiver_stall);

    task automatic send_item(input req_t item);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic access(input logic action, input int row, input int col,
                          input logic signed [VAL_W-1:0] value);
        req_t item;
        item.action = action;
        item.row_index = ROW_W'(row);
        item.column_index = ROW_W'(col);
        item.write_value = value;
        send_item(item);
    endtask

    task automatic drain_items();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    task automatic configure_store(input int rows, input int cols, input int limit_data);
        drain_items();
        cfg_write <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_COLUMN_COUNT;
        cfg_data <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_ENTRY_LIMIT;
        cfg_data <= CFG_DATA_W'(limit_data);
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        rows_now = rows;
        cols_now = cols;
    endtask

    function automatic logic [ROW_W-1:0] pick_coord(input int span, input int bound);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return ROW_W'($urandom_range(1, span));
        if (roll < 90)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return ROW_W'(bound);
                default: return ROW_W'((bound >= 1023) ? 1023 : bound + 1);
            endcase
        end
        return ROW_W'($urandom_range(0, 1023));
    endfunction

    function automatic req_t random_item(input int span, input int remove_pct);
        req_t item;
        int   roll;
        item.action = ($urandom_range(0, 99) < 35) ? ACTION_READ : ACTION_WRITE;
        item.row_index = pick_coord(span, rows_now);
        item.column_index = pick_coord(span, cols_now);
        roll = $urandom_range(0, 99);
        if (roll < remove_pct)
            item.write_value = '0;
        else if (roll < remove_pct + 8)
        begin
            case ($urandom_range(0, 3))
                0:       item.write_value = VALUE_MAX;
                1:       item.write_value = VALUE_MIN;
                2:       item.write_value = 1;
                default: item.write_value = -1;
            endcase
        end
        else
            item.write_value = $urandom;
        return item;
    endfunction

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, corner values, inserts at front, middle and back, removals
        access(ACTION_READ, 1, 1, 0);
        access(ACTION_WRITE, 1, 1, VALUE_MAX);
        access(ACTION_WRITE, 1023, 1023, VALUE_MIN);
        access(ACTION_READ, 1023, 1023, 32'sh5a5a5a5a);
        access(ACTION_WRITE, 1, 1, -1);
        access(ACTION_READ, 1, 1, 0);
        access(ACTION_WRITE, 5, 5, 0);
        access(ACTION_WRITE, 3, 7, 11);
        access(ACTION_WRITE, 3, 2, 22);
        access(ACTION_WRITE, 2, 9, 33);
        access(ACTION_WRITE, 3, 5, 44);
        access(ACTION_READ, 3, 5, 0);
        access(ACTION_WRITE, 3, 5, 0);
        access(ACTION_READ, 3, 5, 0);
        access(ACTION_WRITE, 1, 1, 0);
        access(ACTION_READ, 0, 4, 0);
        access(ACTION_WRITE, 4, 0, 5);

        // full store: insert refused, overwrite and removal still allowed
        configure_store(1023, 1023, 4);
        access(ACTION_WRITE, 7, 7, 9);
        access(ACTION_WRITE, 3, 7, -5);
        access(ACTION_WRITE, 2, 9, 0);
        access(ACTION_WRITE, 7, 7, 9);
        configure_store(10, 10, 4);
        access(ACTION_READ, 11, 3, 0);
        access(ACTION_READ, 10, 10, 0);
        access(ACTION_WRITE, 1023, 1023, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES / 3)
            begin
                sender_idle = 52;
                receiver_stall = 10;
            end
            else if (p == 2 * PHASES / 3)
            begin
                sender_idle = 0;
                receiver_stall = 0;
            end
            configure_store(phase_rows[p], phase_cols[p], phase_limit[p]);
            repeat (ITEMS_PER_PHASE)
                send_item(random_item(phase_span[p], phase_remove[p]));
        end

        drain_items();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sorted_coordinate_sparse_store.f -----
+incdir+sv
sv/scss_pkg.sv
sv/scss_ram.sv
sv/sorted_coordinate_sparse_store.sv
tb/sparse_store_checker.sv
tb/tb_top.sv
